// File: rtl/gdr_pkg.sv
//------------------------------------------------------------------------------
// gdr_pkg
// Shared types, constants and the exp root table for the gated delta column.
//------------------------------------------------------------------------------
`default_nettype none
package gdr_pkg;
    localparam int KMAX_DEF      = 256;
    localparam int FRAC_DEF      = 16;
    localparam int KDIM_W        = 9;
    localparam int IDX_W         = 8;
    localparam int DW            = 32;
    localparam int KDIM_RESET    = 128;
    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_STEP = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic KIND_Y    = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // store write from load_value
        OP_RDREQ,     // issue column read
        OP_LATCH,     // latch v, beta, start exp, clear acc
        OP_EXP,       // one exp iteration
        OP_SREQ,      // issue state read for step
        OP_SDECAY,    // state * decay
        OP_SDOT,      // write back, product with key
        OP_DELTA0,    // v - kv
        OP_DELTA1,    // * beta
        OP_UREQ,      // read element i for update
        OP_UKD,       // key * delta
        OP_UADD,      // add and write back
        OP_UQ,        // state * query, accumulate
        OP_RESULT     // capture result
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] addr;
        logic             bufwr;
    } cmd_t;

    function automatic logic [31:0] root_q30(input int j);
        case (j)
            0: root_q30 = 32'd1518500250;
            1: root_q30 = 32'd1276901416;
            2: root_q30 = 32'd1170923762;
            3: root_q30 = 32'd1121280436;
            4: root_q30 = 32'd1097253709;
            5: root_q30 = 32'd1085434106;
            6: root_q30 = 32'd1079572136;
            default: root_q30 = 32'd1076653033;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction
endpackage
`default_nettype wire

// File: rtl/gdr_ram.sv
//------------------------------------------------------------------------------
// gdr_ram
// Generic single-port RAM with registered read.
//------------------------------------------------------------------------------
`default_nettype none
module gdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: rtl/gdr_datapath.sv
//------------------------------------------------------------------------------
// gdr_datapath
// Column store, key/query buffers, one shared multiplier, exp multipliers, kv and y accumulators.
//------------------------------------------------------------------------------
`default_nettype none
module gdr_datapath #(
    parameter int KMAX      = gdr_pkg::KMAX_DEF,
    parameter int FRAC_BITS = gdr_pkg::FRAC_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gdr_pkg::cmd_t       cmd,
    input  wire logic [31:0]         key_elem,
    input  wire logic [31:0]         query_elem,
    input  wire logic [31:0]         value_in,
    input  wire logic [31:0]         log_decay,
    input  wire logic [31:0]         beta_in,
    input  wire logic [31:0]         load_value,
    input  wire logic                valid_n,   // in-range qualifier for the store address
    output logic [31:0]              result,
    output logic [31:0]              rd_data
);
    localparam int AW = $clog2(KMAX);

    logic [31:0] st_rd, key_rd, q_rd, st_wd;
    logic        st_we;
    logic [AW-1:0] a;
    logic [KMAX-1:0] live_reg;

    // live bit per entry gives the reset contents of the store
    assign a = AW'(cmd.addr);

    gdr_ram #(.WIDTH(32), .DEPTH(KMAX)) u_st (
        .clk(clk), .we(st_we), .addr(a), .wdata(st_wd), .rdata(st_rd));
    gdr_ram #(.WIDTH(32), .DEPTH(KMAX)) u_key (
        .clk(clk), .we(cmd.bufwr), .addr(a), .wdata(key_elem), .rdata(key_rd));
    gdr_ram #(.WIDTH(32), .DEPTH(KMAX)) u_q (
        .clk(clk), .we(cmd.bufwr), .addr(a), .wdata(query_elem), .rdata(q_rd));

    logic        live_rd_reg;
    logic signed [31:0] stv;
    assign stv = live_rd_reg ? st_rd : 32'sd0;

    logic signed [31:0] decay_reg, beta_reg, value_reg, delta_reg, tmp_reg, mb_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] yacc_reg;
    logic [31:0]        exp_r_reg;
    logic [7:0]         exp_idx_reg;
    logic signed [31:0] exp_n_reg;
    logic [3:0]         exp_j_reg;

    // shared signed 32x32 multiplier with floor shift and saturation
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [31:0] qm;
    assign prod = ma * mb;
    assign qm   = gdr_pkg::sat32(66'(prod >>> FRAC_BITS));

    always_comb
    begin
        ma = stv;
        mb = decay_reg;
        st_we = 1'b0;
        st_wd = load_value;
        case (cmd.op)
            gdr_pkg::OP_LOAD:   st_we = 1'b1;
            gdr_pkg::OP_SDECAY: begin ma = stv; mb = decay_reg; end
            gdr_pkg::OP_SDOT:   begin ma = tmp_reg; mb = key_rd;
                                      st_we = 1'b1; st_wd = tmp_reg; end
            gdr_pkg::OP_DELTA1: begin ma = tmp_reg; mb = beta_reg; end
            gdr_pkg::OP_UKD:    begin ma = key_rd; mb = delta_reg; end
            gdr_pkg::OP_UADD:   begin st_we = 1'b1;
                                      st_wd = gdr_pkg::sat32(66'(stv) + 66'(tmp_reg)); end
            gdr_pkg::OP_UQ:     begin ma = tmp_reg; mb = mb_reg; end
            default: ;
        endcase
    end

    // exp pieces: y = floor(x*L/2^30), n = y>>>F, idx = top 8 frac bits
    logic signed [63:0] ey;
    logic signed [63:0] ey_sh;
    assign ey    = $signed(log_decay) * $signed({1'b0, gdr_pkg::LOG2E_Q30});
    assign ey_sh = ey >>> 30;

    // running product stays below 2^31, so 32x32 is enough
    logic [63:0] exp_prod;
    assign exp_prod = 64'(exp_r_reg) * 64'(gdr_pkg::root_q30(int'(exp_j_reg[2:0])));

    logic signed [31:0] exp_s;
    logic [31:0]        exp_shr;
    logic signed [31:0] exp_val;
    always_comb
    begin
        exp_s   = exp_n_reg + 32'(FRAC_BITS) - 32'sd30;
        exp_shr = exp_r_reg >> 6'(-exp_s);
        if (exp_s > 0)
            exp_val = 32'sh7FFF_FFFF;
        else if (exp_s < -32'sd40)
            exp_val = 32'sd0;
        else if (exp_shr > 32'h7FFF_FFFF)
            exp_val = 32'sh7FFF_FFFF;
        else
            exp_val = exp_shr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= '0;
            live_rd_reg <= 1'b0;
            decay_reg   <= '0;
            beta_reg    <= '0;
            value_reg   <= '0;
            delta_reg   <= '0;
            tmp_reg     <= '0;
            mb_reg      <= '0;
            acc_reg     <= '0;
            yacc_reg    <= '0;
            exp_r_reg   <= 32'h4000_0000;
            exp_idx_reg <= '0;
            exp_n_reg   <= '0;
            exp_j_reg   <= '0;
            result      <= '0;
        end
        else
        begin
            live_rd_reg <= live_reg[a] & valid_n;
            if (st_we)
                live_reg[a] <= 1'b1;
            case (cmd.op)
                gdr_pkg::OP_RDREQ: ;
                gdr_pkg::OP_LATCH:
                begin
                    value_reg   <= value_in;
                    beta_reg    <= beta_in;
                    acc_reg     <= '0;
                    exp_n_reg   <= 32'(ey_sh >>> FRAC_BITS);
                    exp_idx_reg <= ey_sh[FRAC_BITS-1 -: 8];
                    exp_r_reg   <= 32'h4000_0000;
                    exp_j_reg   <= '0;
                end
                gdr_pkg::OP_EXP:
                begin
                    if (exp_j_reg[3])
                        decay_reg <= exp_val;
                    else
                    begin
                        if (exp_idx_reg[7 - exp_j_reg[2:0]])
                            exp_r_reg <= 32'(exp_prod >> 30);
                        exp_j_reg <= exp_j_reg + 4'd1;
                    end
                end
                gdr_pkg::OP_SDECAY: tmp_reg <= qm;
                gdr_pkg::OP_SDOT:   acc_reg <= acc_reg + 64'(qm);
                gdr_pkg::OP_DELTA0:
                    tmp_reg <= gdr_pkg::sat32(66'(value_reg)
                                              - 66'(gdr_pkg::sat32(66'(acc_reg))));
                gdr_pkg::OP_DELTA1:
                begin
                    delta_reg <= qm;
                    yacc_reg  <= '0;
                end
                gdr_pkg::OP_UKD:    begin tmp_reg <= qm; mb_reg <= q_rd; end
                gdr_pkg::OP_UADD:
                    tmp_reg <= gdr_pkg::sat32(66'(stv) + 66'(tmp_reg));
                gdr_pkg::OP_UQ:     yacc_reg <= yacc_reg + 64'(qm);
                gdr_pkg::OP_RESULT: result <= gdr_pkg::sat32(66'(yacc_reg));
                default: ;
            endcase
        end
    end

    assign rd_data = stv;
endmodule
`default_nettype wire

// File: rtl/gdr_ctrl.sv
//------------------------------------------------------------------------------
// gdr_ctrl
// Sequencer: decodes items, steps the datapath, drives the output register.
//------------------------------------------------------------------------------
`default_nettype none
module gdr_ctrl #(
    parameter int KMAX = gdr_pkg::KMAX_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic        in_fire,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  elem_index,
    output logic             in_ready,
    output gdr_pkg::cmd_t    cmd,
    output logic             valid_n,
    input  wire logic [31:0] result,
    input  wire logic [31:0] rd_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             out_kind,
    output logic [31:0]      out_value
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDOUT, S_EXP, S_SRD, S_SDEC, S_SDOT, S_D0, S_D1,
        S_URD, S_UKD, S_UADD, S_UQ, S_RES, S_OUT
    } state_t;

    state_t     state_reg;
    logic [8:0] kdim_reg;
    logic [7:0] idx_reg;
    logic [8:0] i_reg;
    logic       last_reg;
    logic [8:0] kd;
    logic [9:0] kmax9;

    assign kmax9 = 10'(KMAX > 256 ? 256 : KMAX);
    always_comb
    begin
        if (kdim_reg == 9'd0)
            kd = 9'd1;
        else if ({1'b0, kdim_reg} > kmax9)
            kd = kmax9[8:0];
        else
            kd = kdim_reg;
    end

    assign in_ready = (state_reg == S_IDLE) && !out_valid;

    always_comb
    begin
        cmd       = '{op: gdr_pkg::OP_NONE, addr: idx_reg, bufwr: 1'b0};
        valid_n   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.addr = elem_index;
                if (in_fire)
                begin
                    if (func == gdr_pkg::FUNC_LOAD && 10'(elem_index) < kmax9)
                        cmd.op = gdr_pkg::OP_LOAD;
                    else if (func == gdr_pkg::FUNC_READ)
                    begin
                        cmd.op  = gdr_pkg::OP_RDREQ;
                        valid_n = 10'(elem_index) < kmax9;
                    end
                    else if (func == gdr_pkg::FUNC_STEP && 9'(elem_index) < kd)
                    begin
                        cmd.bufwr = 1'b1;
                        cmd.op = (elem_index == 8'd0) ? gdr_pkg::OP_LATCH
                                                      : gdr_pkg::OP_SREQ;
                    end
                end
            end
            S_RD:
            begin
                cmd.op  = gdr_pkg::OP_NONE;
                valid_n = 10'(idx_reg) < kmax9;
            end
            S_RDOUT: ;
            S_EXP:  cmd.op = gdr_pkg::OP_EXP;
            S_SRD:  cmd.op = gdr_pkg::OP_SREQ;
            S_SDEC: cmd.op = gdr_pkg::OP_SDECAY;
            S_SDOT: cmd.op = gdr_pkg::OP_SDOT;
            S_D0:   cmd.op = gdr_pkg::OP_DELTA0;
            S_D1:   cmd.op = gdr_pkg::OP_DELTA1;
            S_URD:  begin cmd.op = gdr_pkg::OP_UREQ; cmd.addr = i_reg[7:0]; end
            S_UKD:  begin cmd.op = gdr_pkg::OP_UKD;  cmd.addr = i_reg[7:0]; end
            S_UADD: begin cmd.op = gdr_pkg::OP_UADD; cmd.addr = i_reg[7:0]; end
            S_UQ:   begin cmd.op = gdr_pkg::OP_UQ;   cmd.addr = i_reg[7:0]; end
            S_RES:  cmd.op = gdr_pkg::OP_RESULT;
            S_OUT:  ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kdim_reg  <= 9'(gdr_pkg::KDIM_RESET);
            out_valid <= 1'b0;
            idx_reg   <= '0;
            i_reg     <= '0;
            last_reg  <= 1'b0;
            out_kind  <= gdr_pkg::KIND_Y;
            out_value <= '0;
        end
        else
        begin
            if (cfg_we)
                kdim_reg <= cfg_wdata;
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_fire)
                    begin
                        idx_reg  <= elem_index;
                        last_reg <= 9'(elem_index) == kd - 9'd1;
                        if (func == gdr_pkg::FUNC_READ)
                            state_reg <= S_RD;
                        else if (func == gdr_pkg::FUNC_STEP && 9'(elem_index) < kd)
                            state_reg <= (elem_index == 8'd0) ? S_EXP : S_SDEC;
                    end
                S_RD:    state_reg <= S_RDOUT;
                S_RDOUT:
                begin
                    out_kind  <= gdr_pkg::KIND_READ;
                    out_value <= rd_data;
                    out_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_EXP:
                begin
                    i_reg <= i_reg + 9'd1;
                    if (i_reg == 9'd8)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_SRD;
                    end
                end
                S_SRD:  state_reg <= S_SDEC;
                S_SDEC: state_reg <= S_SDOT;
                S_SDOT:
                begin
                    i_reg     <= '0;
                    state_reg <= last_reg ? S_D0 : S_IDLE;
                end
                S_D0:   state_reg <= S_D1;
                S_D1:   state_reg <= S_URD;
                S_URD:  state_reg <= S_UKD;
                S_UKD:  state_reg <= S_UADD;
                S_UADD: state_reg <= S_UQ;
                S_UQ:
                begin
                    i_reg <= i_reg + 9'd1;
                    state_reg <= (i_reg + 9'd1 == kd) ? S_RES : S_URD;
                end
                S_RES:  state_reg <= S_OUT;
                S_OUT:
                begin
                    out_kind  <= gdr_pkg::KIND_Y;
                    out_value <= result;
                    out_valid <= 1'b1;
                    i_reg     <= '0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/gated_delta_rule_column.sv
//------------------------------------------------------------------------------
// gated_delta_rule_column
// One value column of a gated delta rule recurrence in signed fixed point.
//------------------------------------------------------------------------------
// One item at a time, set by a single shared multiplier and single-port
// memories. A step item at index 0 first runs the exp iterations. The last
// step item then forms delta, runs an update pass over every key dimension
// and presents y. The state store resets to zero through per-entry valid
// bits; no clearing pass.
`default_nettype none
module gated_delta_rule_column #(
    parameter int KMAX      = gdr_pkg::KMAX_DEF,
    parameter int FRAC_BITS = gdr_pkg::FRAC_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [8:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // func[1:0], elem_index[9:2], key_elem[41:10], query_elem[73:42],
    // value_in[105:74], log_decay[137:106], beta_in[169:138],
    // load_value[201:170], zero pad
    input  wire logic [207:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // out_value[31:0]
    output logic              m_tuser    // out_kind
);
    gdr_pkg::cmd_t cmd;
    logic          valid_n;
    logic [31:0]   result, rd_data;
    logic          in_fire;

    assign in_fire = s_tvalid && s_tready;

    gdr_ctrl #(.KMAX(KMAX)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_fire(in_fire), .func(s_tdata[1:0]), .elem_index(s_tdata[9:2]),
        .in_ready(s_tready), .cmd(cmd), .valid_n(valid_n),
        .result(result), .rd_data(rd_data),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_kind(m_tuser), .out_value(m_tdata));

    gdr_datapath #(.KMAX(KMAX), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .key_elem(s_tdata[41:10]), .query_elem(s_tdata[73:42]),
        .value_in(s_tdata[105:74]), .log_decay(s_tdata[137:106]),
        .beta_in(s_tdata[169:138]), .load_value(s_tdata[201:170]),
        .valid_n(valid_n), .result(result), .rd_data(rd_data));
endmodule
`default_nettype wire

// File: rtl/gdr_checker.sv
//------------------------------------------------------------------------------
// gdr_checker
// Port-level checks, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none
module gdr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_tvalid, s_tready, m_tvalid, m_tready}))
        else $error("handshake signal unknown");
    a_noin: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input open while result pending");
endmodule

bind gated_delta_rule_column gdr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser));
`default_nettype wire

// File: verif/gated_delta_rule_column_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// gated_delta_rule_column_tb
// Drives load, read and timestep items into the gated delta column, predicts
// each y and read result with a fixed point column model, and compares them.
//------------------------------------------------------------------------------
module gated_delta_rule_column_tb;
    localparam int KMAX = 256;
    localparam int FRAC = 16;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    typedef struct packed {
        logic [31:0] value;
        logic        kind;
    } result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [8:0]   cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [207:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic         m_tuser;

    gated_delta_rule_column dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #6 clk = ~clk;

    // column model
    logic signed [31:0] col_state [KMAX];
    logic signed [31:0] key_mem [KMAX];
    logic signed [31:0] qry_mem [KMAX];
    logic signed [63:0] kv_sum;
    logic signed [31:0] decay_q, beta_q, value_q;
    logic [8:0]         kdim_reg;

    result_t pending_results[$];
    int  mismatches = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    longint cycles = 0;

    function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return clip32(p >>> FRAC);
    endfunction

    function automatic logic signed [31:0] fx_exp(input logic signed [31:0] x);
        logic signed [95:0] y;
        logic signed [95:0] n;
        logic [7:0]         frac_sel;
        logic [63:0]        r;
        longint             sh;
        logic [63:0]        roots [8];
        roots = '{64'd1518500250, 64'd1276901416, 64'd1170923762, 64'd1121280436,
                  64'd1097253709, 64'd1085434106, 64'd1079572136, 64'd1076653033};
        y = (96'(x) * 96'sd1549082005) >>> 30;
        n = y >>> FRAC;
        frac_sel = y[FRAC-1 -: 8];
        r = 64'd1 << 30;
        for (int j = 0; j < 8; j++)
            if (frac_sel[7-j]) r = (r * roots[j]) >> 30;
        sh = longint'(n) + FRAC - 30;
        if (sh > 0) return 32'sh7FFF_FFFF;
        if (sh < -40) return 0;
        r = r >> (-sh);
        if (r > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
        return r[31:0];
    endfunction

    function automatic int active_dims();
        if (kdim_reg == 0) return 1;
        if (kdim_reg > KMAX) return KMAX;
        return kdim_reg;
    endfunction

    task automatic predict_column(input logic [207:0] d);
        logic [1:0] fn;
        int idx, kd;
        logic signed [31:0] delta;
        logic signed [63:0] acc;
        result_t r;
        fn = d[1:0];
        idx = d[9:2];
        kd = active_dims();
        if (fn == gdr_pkg::FUNC_LOAD) begin
            col_state[idx] = d[201:170];
        end else if (fn == gdr_pkg::FUNC_READ) begin
            r.kind = gdr_pkg::KIND_READ;
            r.value = col_state[idx];
            pending_results.push_back(r);
        end else if (fn == gdr_pkg::FUNC_STEP && idx < kd) begin
            if (idx == 0) begin
                decay_q = fx_exp(d[137:106]);
                beta_q = d[169:138];
                value_q = d[105:74];
                kv_sum = 0;
            end
            key_mem[idx] = d[41:10];
            qry_mem[idx] = d[73:42];
            col_state[idx] = fx_mul(col_state[idx], decay_q);
            kv_sum += 64'(fx_mul(col_state[idx], key_mem[idx]));
            if (idx == kd - 1) begin
                delta = fx_mul(clip32(66'(value_q) - 66'(clip32(66'(kv_sum)))), beta_q);
                acc = 0;
                for (int i = 0; i < kd; i++) begin
                    col_state[i] = clip32(66'(col_state[i]) + 66'(fx_mul(key_mem[i], delta)));
                    acc += 64'(fx_mul(col_state[i], qry_mem[i]));
                end
                r.kind = gdr_pkg::KIND_Y;
                r.value = clip32(66'(acc));
                pending_results.push_back(r);
            end
        end
    endtask

    // tvalid stays high after acceptance until the next idle cycle or a drain
    task automatic send_item(input logic [207:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata <= d;
        s_tvalid <= 1'b1;
        predict_column(d);
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic logic [207:0] pack_item(input logic [1:0] fn, input int idx,
        input logic [31:0] k, input logic [31:0] q, input logic [31:0] v,
        input logic [31:0] g, input logic [31:0] b, input logic [31:0] ld);
        return {6'd0, ld, b, g, v, q, k, 8'(idx), fn};
    endfunction

    function automatic logic [31:0] rnd_small();
        // mostly values near one so the state stays in range
        case ($urandom_range(3))
            0: return $urandom;
            default: return 32'($signed($urandom_range(262143)) - 131072);
        endcase
    endfunction

    function automatic logic [31:0] rnd_decay();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(4194303)) - 2097152);
            default: return 32'(-$signed($urandom_range(65535)));
        endcase
    endfunction

    task automatic send_step(input int idx, input logic [31:0] g);
        send_item(pack_item(gdr_pkg::FUNC_STEP, idx, rnd_small(), rnd_small(),
                            rnd_small(), g, rnd_small(), $urandom));
    endtask

    task automatic send_timestep();
        logic [31:0] g;
        g = rnd_decay();
        for (int i = 0; i < active_dims(); i++) send_step(i, g);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_kdim(input logic [8:0] v);
        drain_results();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        kdim_reg = v;
    endtask

    // result checker
    always @(posedge clk) begin
        result_t want;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind %0d value %h", m_tuser, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (want.kind !== m_tuser || want.value !== m_tdata) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected kind %0d value %h, got %0d %h",
                                 want.kind, want.value, m_tuser, m_tdata);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        logic [31:0] ext [4];
        ext = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        write_kdim(9'd2);
        foreach (ext[i]) begin
            send_item(pack_item(gdr_pkg::FUNC_LOAD, 255, '1, '1, '1, '1, '1, ext[i]));
            send_item(pack_item(gdr_pkg::FUNC_READ, 255, '0, '0, '0, '0, '0, '0));
        end
        send_item(pack_item(gdr_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0, 32'h0001_0000));
        send_item(pack_item(gdr_pkg::FUNC_LOAD, 1, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send_item(pack_item(2'd3, 0, '1, '1, '1, '1, '1, '1));
        send_item(pack_item(gdr_pkg::FUNC_STEP, 5, 1, 1, 1, 1, 1, 1));
        // extreme scalars: big exp saturates, very negative underflows
        send_item(pack_item(gdr_pkg::FUNC_STEP, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        send_item(pack_item(gdr_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
        send_item(pack_item(gdr_pkg::FUNC_STEP, 1, 32'h8000_0000, 32'h7FFF_FFFF,
                            0, 0, 0, 0));
        send_item(pack_item(gdr_pkg::FUNC_STEP, 0, 32'h0001_0000, 32'h0001_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        send_item(pack_item(gdr_pkg::FUNC_STEP, 1, 32'hFFFF_0000, 32'hFFFF_FFFF,
                            0, 0, 0, 0));
        // repeated last index keeps accumulating onto the old kv sum
        send_item(pack_item(gdr_pkg::FUNC_STEP, 1, 32'h0002_0000, 32'h0001_0000,
                            0, 0, 0, 0));
        send_item(pack_item(gdr_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(gdr_pkg::FUNC_READ, 1, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_min_kdim();
        write_kdim(9'd0);
        repeat (10) send_timestep();
        write_kdim(9'd1);
        repeat (10) send_timestep();
    endtask

    task automatic test_random(input int n_items, input logic [8:0] kd);
        int sent;
        write_kdim(kd);
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0: begin
                    send_item(pack_item(gdr_pkg::FUNC_LOAD, $urandom_range(255), $urandom,
                        $urandom, $urandom, $urandom, $urandom, rnd_small()));
                    sent++;
                end
                1: begin
                    send_item(pack_item(gdr_pkg::FUNC_READ, $urandom_range(255), $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom));
                    sent++;
                end
                2: begin
                    // out of range step index or unknown func
                    send_item(pack_item($urandom_range(1) ? 2'd3 : gdr_pkg::FUNC_STEP,
                        $urandom_range(255, active_dims()) % 256, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom));
                    sent++;
                end
                default: begin
                    send_timestep();
                    sent += active_dims();
                end
            endcase
        end
    endtask

    initial begin
        foreach (col_state[i]) col_state[i] = 0;
        foreach (key_mem[i]) key_mem[i] = 0;
        foreach (qry_mem[i]) qry_mem[i] = 0;
        kv_sum = 0;
        decay_q = 0;
        beta_q = 0;
        value_q = 0;
        kdim_reg = 9'd128;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_min_kdim();
        send_idle_pct = 21;
        recv_idle_pct = 49;
        test_random(330, 9'd4);
        send_idle_pct = 49;
        recv_idle_pct = 21;
        test_random(330, 9'd7);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(250, 9'd3);
        test_random(256, 9'd256);
        test_random(60, 9'd511);
        drain_results();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: gated_delta_rule_column.f
rtl/gdr_pkg.sv
rtl/gdr_ram.sv
rtl/gdr_datapath.sv
rtl/gdr_ctrl.sv
rtl/gated_delta_rule_column.sv
rtl/gdr_checker.sv
verif/gated_delta_rule_column_tb.sv
